FILE: hdl/mbps_pkg.sv
`default_nettype none

package mbps_pkg;

  // Sizing defaults
  localparam int MAX_PATTERN_BYTES = 8;
  localparam int PATTERN_SLOTS     = 2;
  localparam int OFFSET_BITS       = 32;

  // Fixed field widths
  localparam int LEN_W      = 4;
  localparam int PAT_W      = 64;
  localparam int OFFSET_W   = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  // Register map, one 64-bit word per register at 8*index
  typedef enum logic [REG_IDX_W-1:0] {
    REG_FIRST_LEN   = 3'd0,
    REG_FIRST_VAL   = 3'd1,
    REG_FIRST_MASK  = 3'd2,
    REG_SECOND_LEN  = 3'd3,
    REG_SECOND_VAL  = 3'd4,
    REG_SECOND_MASK = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: hdl/masked_byte_pattern_search_top.sv
`default_nettype none

// Channel  | handshake          | payload
// ---------+--------------------+--------------------------------------------------
// in_      | in_valid/in_ready  | data_byte[7:0], first_of_search, last_of_stream
// out_     | out_valid/out_ready| found, pattern_number, start_offset[31:0]
// cfg_     | APB write/read     | paddr[5:0] (reg at 8*index), pwdata/prdata[63:0]
//
// One beat per cycle sustained while the result register drains. An accepted
// beat is held in the input stage; when the result register is free, its
// compares and count update are registered into the result register.
// Reset (rst_n low, synchronous) empties both stages, clears the byte count,
// sets the done flag (bytes ignored until first_of_search) and loads the
// length/value/mask registers with their defaults; the history is not reset.
// A stalled result register holds the input stage; the input stage keeps
// taking beats as long as it can drain.
module masked_byte_pattern_search_top #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES,
  parameter int PATTERN_SLOTS     = mbps_pkg::PATTERN_SLOTS,
  parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // byte stream in
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic                            in_first_of_search,
  input  wire logic                            in_last_of_stream,
  // search result out
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_found,
  output logic                                 out_pattern_number,
  output logic [mbps_pkg::OFFSET_W-1:0]        out_start_offset,
  // configuration
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [mbps_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [mbps_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [mbps_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int LEN_W   = mbps_pkg::LEN_W;
  localparam int PAT_W   = mbps_pkg::PAT_W;
  localparam int HIST_W  = MAX_PATTERN_BYTES * 8;
  // byte count saturates at 2^min(OFFSET_BITS,32)-1
  localparam int CNT_W   = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN_BYTES);

  // ---------------------------------------------------------------- config
  logic [LEN_W-1:0] len0_r, len1_r;
  logic [PAT_W-1:0] val0_r, val1_r, msk0_r, msk1_r;
  logic             cfg_wr;
  mbps_pkg::cfg_reg_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = mbps_pkg::cfg_reg_t'(cfg_paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len0_r <= '0;
      val0_r <= '0;
      msk0_r <= '1;
      len1_r <= '0;
      val1_r <= '0;
      msk1_r <= '1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mbps_pkg::REG_FIRST_LEN:   len0_r <= cfg_pwdata[LEN_W-1:0];
        mbps_pkg::REG_FIRST_VAL:   val0_r <= cfg_pwdata;
        mbps_pkg::REG_FIRST_MASK:  msk0_r <= cfg_pwdata;
        mbps_pkg::REG_SECOND_LEN:  len1_r <= cfg_pwdata[LEN_W-1:0];
        mbps_pkg::REG_SECOND_VAL:  val1_r <= cfg_pwdata;
        mbps_pkg::REG_SECOND_MASK: msk1_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mbps_pkg::REG_FIRST_LEN:   cfg_prdata = {{(PAT_W-LEN_W){1'b0}}, len0_r};
      mbps_pkg::REG_FIRST_VAL:   cfg_prdata = val0_r;
      mbps_pkg::REG_FIRST_MASK:  cfg_prdata = msk0_r;
      mbps_pkg::REG_SECOND_LEN:  cfg_prdata = {{(PAT_W-LEN_W){1'b0}}, len1_r};
      mbps_pkg::REG_SECOND_VAL:  cfg_prdata = val1_r;
      mbps_pkg::REG_SECOND_MASK: cfg_prdata = msk1_r;
      default:                   cfg_prdata = '0;
    endcase
  end

  // ----------------------------------------------------------- input stage
  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_first_r, s1_last_r;
  logic       s2_free, s1_fire, in_fire;

  assign s2_free  = !out_valid || out_ready;
  assign s1_fire  = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r  <= in_data_byte;
      s1_first_r <= in_first_of_search;
      s1_last_r  <= in_last_of_stream;
    end
  end

  // --------------------------------------------------------- search state
  logic [HIST_W-1:0] hist_r, hist_nxt;  // byte 0 is newest
  logic [CNT_W-1:0]  cnt_r, cnt_base, cnt_nxt;
  logic              done_r, done_base;

  // ignored beats (done set) leave history and count untouched
  always_comb begin
    cnt_base  = s1_first_r ? '0 : cnt_r;
    done_base = s1_first_r ? 1'b0 : done_r;
    cnt_nxt   = (cnt_base == '1) ? cnt_base : cnt_base + CNT_W'(1);
    hist_nxt[7:0] = s1_data_r;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      hist_nxt[8*k +: 8] = hist_r[8*(k-1) +: 8];
    end
  end

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    clamp_len = (len > LEN_MAX) ? LEN_MAX : len;
  endfunction

  // all masked byte compares of one pattern in parallel
  function automatic logic slot_hit(input logic [LEN_W-1:0]  len,
                                    input logic [PAT_W-1:0]  val,
                                    input logic [PAT_W-1:0]  msk,
                                    input logic [HIST_W-1:0] hist,
                                    input logic [CNT_W-1:0]  cnt);
    logic hit;
    hit = (len != '0) && (cnt >= CNT_W'(len));
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      if ((k < int'(len)) && ((hist[8*k +: 8] & msk[8*k +: 8]) != val[8*k +: 8])) begin
        hit = 1'b0;
      end
    end
    slot_hit = hit;
  endfunction

  logic [LEN_W-1:0] len0_c, len1_c, len_sel;
  logic             hit0, hit1;
  logic             res_valid, res_found, res_pat;
  logic [CNT_W-1:0] res_offset;

  always_comb begin
    len0_c = clamp_len(len0_r);
    len1_c = clamp_len(len1_r);
    hit0   = slot_hit(len0_c, val0_r, msk0_r, hist_nxt, cnt_nxt);
    hit1   = (PATTERN_SLOTS > 1) && slot_hit(len1_c, val1_r, msk1_r, hist_nxt, cnt_nxt);
    // lower pattern number wins a tie
    res_found = hit0 || hit1;
    res_pat   = !hit0 && hit1;
    len_sel   = hit0 ? len0_c : len1_c;
    res_valid = !done_base && (res_found || s1_last_r);
    res_offset = res_found ? (cnt_nxt - CNT_W'(len_sel)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b1;
    end else if (s1_fire) begin
      cnt_r  <= done_base ? cnt_base : cnt_nxt;
      done_r <= done_base || res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && !done_base) begin
      hist_r <= hist_nxt;
    end
  end

  // ------------------------------------------------------ result register
  logic                          out_valid_r;
  logic                          out_found_r, out_pat_r;
  logic [mbps_pkg::OFFSET_W-1:0] out_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_found_r  <= res_found;
      out_pat_r    <= res_pat;
      out_offset_r <= mbps_pkg::OFFSET_W'(res_offset);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_pattern_number = out_pat_r;
  assign out_start_offset   = out_offset_r;

  // ------------------------------------------------------------ checks
  a_result_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && res_valid |=> done_r)
    else $error("search still open after a result");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_start_offset == '0) && !out_pattern_number)
    else $error("not-found result carries nonzero fields");

  a_slot_exists: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pattern_number |-> PATTERN_SLOTS > 1)
    else $error("result names a pattern slot that does not exist");

  a_ignored_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && done_r && !s1_first_r |=> !out_valid)
    else $error("result from a beat of a finished search");

endmodule

`default_nettype wire

FILE: tb/tb_masked_byte_pattern_search_top.sv
`timescale 1ns / 1ps

module tb_masked_byte_pattern_search_top;

  // Run shape
  localparam int          RUN_LIMIT_NS     = 4_000_000; // generous fixed watchdog
  localparam int unsigned RANDOM_BEATS     = 340;       // beats sent in the random part
  localparam int unsigned PHASE_BEATS      = 80;        // beats sent per pattern setting
  localparam int unsigned BURST_BEATS      = 24;        // beats pushed against a stalled sink
  localparam int unsigned LONG_HOLD_CYCLES = 64;        // sink hold-off length
  localparam int unsigned SETTLE_CYCLES    = 6;         // extra wait for the pipeline to settle

  localparam logic APB_WRITE = 1'b1;
  localparam logic APB_READ  = 1'b0;

  typedef struct packed {
    logic                          found;
    logic                          pattern_number;
    logic [mbps_pkg::OFFSET_W-1:0] start_offset;
  } search_result_t;

  logic clk;
  logic rst_n;

  logic                            in_valid;
  logic                            in_ready;
  logic [7:0]                      in_data_byte;
  logic                            in_first_of_search;
  logic                            in_last_of_stream;
  logic                            out_valid;
  logic                            out_ready;
  logic                            out_found;
  logic                            out_pattern_number;
  logic [mbps_pkg::OFFSET_W-1:0]   out_start_offset;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [mbps_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  masked_byte_pattern_search_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_first_of_search (in_first_of_search),
    .in_last_of_stream  (in_last_of_stream),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_pattern_number (out_pattern_number),
    .out_start_offset   (out_start_offset),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Search predictor state: register shadow, byte history, count, done flag.
  // History entry 0 is the newest byte.
  // ---------------------------------------------------------------------------
  logic [63:0]                   reg_shadow [6];
  logic [7:0]                    hist_bytes [8];
  logic [mbps_pkg::OFFSET_W-1:0] seen_count;
  logic                          search_idle;
  search_result_t                expected_results [$];

  int unsigned sent_beats;   // every beat accepted by the block, ignored ones too
  int unsigned error_count;
  bit          jitter_on;    // random gaps on both channels
  bit          sink_hold_req;

  // First register of a pattern slot; value and mask follow it.
  function automatic int slot_base(int slot);
    return (slot == 0) ? mbps_pkg::REG_FIRST_LEN : mbps_pkg::REG_SECOND_LEN;
  endfunction

  // Effective length: overlong settings clip to the history depth.
  function automatic int pattern_bytes(int slot);
    int n;
    n = int'(reg_shadow[slot_base(slot)][mbps_pkg::LEN_W-1:0]);
    return (n > mbps_pkg::MAX_PATTERN_BYTES) ? mbps_pkg::MAX_PATTERN_BYTES : n;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    if (!jitter_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Applies one accepted beat; queues the result it causes, if any.
  function automatic void predict_search_beat(logic [7:0] data, logic first, logic last);
    search_result_t r;
    int             plen;
    bit             hit;
    bit             ok;
    logic [63:0]    pv;
    logic [63:0]    pm;
    r = '0;
    if (first) begin
      seen_count  = '0;
      search_idle = 1'b0;
    end
    // idle: ignored, even on last
    if (search_idle) return;
    for (int k = 7; k > 0; k--) hist_bytes[k] = hist_bytes[k-1];
    hist_bytes[0] = data;
    if (seen_count != '1) seen_count++;
    hit = 1'b0;
    // slot 0 first, so it wins ties
    for (int slot = 0; slot < mbps_pkg::PATTERN_SLOTS && !hit; slot++) begin
      plen = pattern_bytes(slot);
      pv   = reg_shadow[slot_base(slot) + 1];
      pm   = reg_shadow[slot_base(slot) + 2];
      // count guard: only bytes of this search are compared
      if (plen != 0 && seen_count >= plen) begin
        ok = 1'b1;
        for (int k = 0; k < plen; k++) begin
          if ((hist_bytes[k] & pm[8*k +: 8]) != pv[8*k +: 8]) ok = 1'b0;
        end
        if (ok) begin
          hit              = 1'b1;
          r.found          = 1'b1;
          r.pattern_number = slot[0];
          r.start_offset   = seen_count - mbps_pkg::OFFSET_W'(plen);
        end
      end
    end
    // not-found only when nothing matched on the last byte
    if (!hit && last) hit = 1'b1;
    if (hit) begin
      expected_results.insert(expected_results.size(), r);
      search_idle = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every out_ beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_checker
    search_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: found=%0d pattern_number=%0d start_offset=%0d",
               out_found, out_pattern_number, out_start_offset);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_found !== exp_r.found) begin
          $error("found: expected %0d, got %0d", exp_r.found, out_found);
          error_count++;
        end
        if (out_pattern_number !== exp_r.pattern_number) begin
          $error("pattern_number: expected %0d, got %0d",
                 exp_r.pattern_number, out_pattern_number);
          error_count++;
        end
        if (out_start_offset !== exp_r.start_offset) begin
          $error("start_offset: expected %0d, got %0d", exp_r.start_offset, out_start_offset);
          error_count++;
        end
      end
    end
  end

  // Result sink: random stalls, plus a long counted hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold_left     = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready  = 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. All tasks start and end on a falling edge. A beat left valid by
  // send_beat is either replaced by the next send_beat at that same edge or
  // dropped by the first thing any other task does.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] data, input logic first, input logic last);
    int unsigned gap;
    in_valid           = 1'b1;
    in_data_byte       = data;
    in_first_of_search = first;
    in_last_of_stream  = last;
    do @(posedge clk); while (!in_ready);
    sent_beats++;
    predict_search_beat(data, first, last);
    @(negedge clk);
    gap = idle_len();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Waits out every queued result plus the pipeline, so the block is idle.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // One APB transfer: setup, then access until pready. Reads are checked.
  task automatic cfg_access(input logic is_write, input mbps_pkg::cfg_reg_t idx,
                            input logic [63:0] wdata);
    in_valid = 1'b0;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = is_write;
    cfg_paddr   = {idx, 3'b000};
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (is_write) begin
      // length registers keep only their low nibble
      if (idx == mbps_pkg::REG_FIRST_LEN || idx == mbps_pkg::REG_SECOND_LEN) begin
        reg_shadow[idx] = wdata & 64'hF;
      end else begin
        reg_shadow[idx] = wdata;
      end
    end else if (cfg_prdata !== reg_shadow[idx]) begin
      $error("%s: expected %0h, got %0h", idx.name(), reg_shadow[idx], cfg_prdata);
      error_count++;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_pattern(input int slot, input logic [63:0] len_word,
                             input logic [63:0] value, input logic [63:0] mask);
    cfg_access(APB_WRITE, mbps_pkg::cfg_reg_t'(slot_base(slot)), len_word);
    cfg_access(APB_WRITE, mbps_pkg::cfg_reg_t'(slot_base(slot) + 1), value);
    cfg_access(APB_WRITE, mbps_pkg::cfg_reg_t'(slot_base(slot) + 2), mask);
  endtask

  // New random setting for both slots: lengths incl. off and overlong,
  // byte masks of all kinds, and now and then value bits outside the mask.
  task automatic randomize_patterns();
    logic [63:0] pm;
    logic [63:0] pv;
    logic [63:0] len_word;
    int          r;
    for (int slot = 0; slot < mbps_pkg::PATTERN_SLOTS; slot++) begin
      r        = $urandom_range(0, 99);
      len_word = {$urandom, $urandom};
      if (r < 8)       len_word[3:0] = 4'd0;
      else if (r < 85) len_word[3:0] = 4'($urandom_range(1, 8));
      else             len_word[3:0] = 4'($urandom_range(9, 15));
      for (int k = 0; k < 8; k++) begin
        case ($urandom_range(0, 4))
          0, 1:    pm[8*k +: 8] = 8'hFF;
          2:       pm[8*k +: 8] = $urandom_range(0, 1) ? 8'h0F : 8'hF0;
          3:       pm[8*k +: 8] = 8'h00;
          default: pm[8*k +: 8] = 8'($urandom);
        endcase
      end
      if ($urandom_range(0, 9) == 0) pm = '1;
      pv = {$urandom, $urandom};
      if ($urandom_range(0, 9) != 0) pv &= pm;
      set_pattern(slot, len_word, pv, pm);
    end
  endtask

  // One search: mostly short, a few long; often carries a planted copy of a
  // pattern (masked-out bits random). Rare restarts, rare missing last byte,
  // occasional stray beat afterwards.
  task automatic send_random_search();
    int          n;
    int          slot;
    int          plen;
    int          plant_end;
    int          k;
    bit          plant;
    bit          broken;
    logic [7:0]  b;
    logic [63:0] pv;
    logic [63:0] pm;
    n         = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 16) : $urandom_range(30, 60);
    slot      = $urandom_range(0, mbps_pkg::PATTERN_SLOTS - 1);
    plen      = pattern_bytes(slot);
    pv        = reg_shadow[slot_base(slot) + 1];
    pm        = reg_shadow[slot_base(slot) + 2];
    plant     = (plen != 0) && (plen <= n) && ($urandom_range(0, 99) < 60);
    plant_end = plant ? $urandom_range(plen - 1, n - 1) : -1;
    broken    = ($urandom_range(0, 99) < 5);
    for (int i = 0; i < n; i++) begin
      if (plant && i > plant_end - plen && i <= plant_end) begin
        k = plant_end - i;
        b = pv[8*k +: 8] | (8'($urandom) & ~pm[8*k +: 8]);
      end else if ($urandom_range(0, 99) < 60) begin
        k = $urandom_range(0, 7);
        b = reg_shadow[slot_base($urandom_range(0, mbps_pkg::PATTERN_SLOTS - 1)) + 1][8*k +: 8];
      end else begin
        b = 8'($urandom);
      end
      send_beat(b, (i == 0) || ($urandom_range(0, 99) < 3), (i == n - 1) && !broken);
    end
    if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values read back, then every register written and read back.
  task automatic test_register_map();
    logic [63:0] wdata;
    for (int i = 0; i < 6; i++) cfg_access(APB_READ, mbps_pkg::cfg_reg_t'(i), '0);
    for (int i = 0; i < 6; i++) begin
      wdata = {$urandom, $urandom};
      cfg_access(APB_WRITE, mbps_pkg::cfg_reg_t'(i), wdata);
      cfg_access(APB_READ, mbps_pkg::cfg_reg_t'(i), '0);
    end
  endtask

  task automatic test_directed_cases();
    wait_drained();
    // slot 0 = "ABC", slot 1 = "BC", exact compare
    set_pattern(0, 64'd3, 64'h41_42_43, '1);
    set_pattern(1, 64'd2, 64'h42_43, '1);

    // idle after reset: ignored, even with last set
    send_beat(8'h00, 1'b0, 1'b1);
    // both match on 'C': slot 0 wins at offset 0; trailing last is ignored
    send_beat(8'h41, 1'b1, 1'b0);
    send_beat(8'h42, 1'b0, 1'b0);
    send_beat(8'h43, 1'b0, 1'b0);
    send_beat(8'h58, 1'b0, 1'b1);
    // slot 1 matches on the last byte, no not-found after it
    send_beat(8'h5A, 1'b1, 1'b0);
    send_beat(8'h42, 1'b0, 1'b0);
    send_beat(8'h43, 1'b0, 1'b1);
    // plain not-found
    send_beat(8'h42, 1'b1, 1'b0);
    send_beat(8'h51, 1'b0, 1'b1);
    // restart mid-search: "ABC" is in the history but the count guard blocks it
    send_beat(8'h41, 1'b1, 1'b0);
    send_beat(8'h42, 1'b0, 1'b0);
    send_beat(8'h43, 1'b1, 1'b0);
    send_beat(8'h44, 1'b0, 1'b1);
    // one-byte search
    send_beat(8'hFF, 1'b1, 1'b1);

    wait_drained();
    // overlong length (all upper bits set too) with a zero mask: hits once
    // eight bytes are in; slot 1 has a value bit outside its mask, never hits
    set_pattern(0, '1, '0, '0);
    set_pattern(1, 64'd1, 64'hF0, 64'h0F);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b0);
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h01, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b0);
    send_beat(8'hFE, 1'b0, 1'b0);
    send_beat(8'h7F, 1'b0, 1'b1);
  endtask

  // Sink held off while one-beat searches keep coming: the block fills and
  // stalls its input. Then the sender pauses until all results are in.
  task automatic test_backpressure();
    wait_drained();
    set_pattern(0, 64'd1, '0, '0);   // any byte is a hit
    set_pattern(1, 64'd0, '1, '1);
    jitter_on     = 1'b0;
    sink_hold_req = 1'b1;
    for (int i = 0; i < BURST_BEATS; i++) begin
      send_beat(8'($urandom), 1'b1, 1'($urandom_range(0, 1)));
    end
    wait_drained();
    jitter_on = 1'b1;
  endtask

  task automatic test_random_searches();
    int unsigned stop_mark;
    int unsigned phase_mark;
    stop_mark = sent_beats + RANDOM_BEATS;
    wait_drained();
    randomize_patterns();
    phase_mark = sent_beats;
    while (sent_beats < stop_mark) begin
      if (sent_beats - phase_mark >= PHASE_BEATS) begin
        wait_drained();
        randomize_patterns();
        jitter_on  = ($urandom_range(0, 3) != 0);   // some phases run gap-free
        phase_mark = sent_beats;
      end
      send_random_search();
    end
    jitter_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_valid           = 1'b0;
    in_data_byte       = '0;
    in_first_of_search = 1'b0;
    in_last_of_stream  = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    error_count        = 0;
    sent_beats         = 0;
    jitter_on          = 1'b1;
    sink_hold_req      = 1'b0;

    // reset state of the predictor
    reg_shadow[mbps_pkg::REG_FIRST_LEN]   = '0;
    reg_shadow[mbps_pkg::REG_FIRST_VAL]   = '0;
    reg_shadow[mbps_pkg::REG_FIRST_MASK]  = '1;
    reg_shadow[mbps_pkg::REG_SECOND_LEN]  = '0;
    reg_shadow[mbps_pkg::REG_SECOND_VAL]  = '0;
    reg_shadow[mbps_pkg::REG_SECOND_MASK] = '1;
    for (int k = 0; k < 8; k++) hist_bytes[k] = '0;
    seen_count  = '0;
    search_idle = 1'b1;   // idle until first_of_search

    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_register_map();
    test_directed_cases();
    test_backpressure();
    test_random_searches();

    wait_drained();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
hdl/mbps_pkg.sv
hdl/masked_byte_pattern_search_top.sv
tb/tb_masked_byte_pattern_search_top.sv
